/* hw/rtl/sample_playback_voice_unit_macros.svh */
// -----------------------------------------------------------------------------
// Sample playback voice: assertion macros
// Concurrent checks on clk_i, disabled while rst_ni is low. Empty for synthesis.
// -----------------------------------------------------------------------------
`ifndef SAMPLE_PLAYBACK_VOICE_UNIT_MACROS_SVH
`define SAMPLE_PLAYBACK_VOICE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define SPV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define SPV_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);
`else
`define SPV_ASSERT(lbl, prop, msg)
`define SPV_ASSERT_IMPLIES(lbl, ante, cons, msg)
`endif
`endif

/* hw/rtl/spv_pkg.sv */
// -----------------------------------------------------------------------------
// Sample playback voice package
// Shared types, codes and constants of the voice and its remainder unit.
// -----------------------------------------------------------------------------
package spv_pkg;

  localparam int DefStoreDepth = 65536;
  localparam int DefSampleBits = 16;

  // configuration port
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 20;

  localparam logic [CfgIdxW-1:0] CFG_RATE_STEP       = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_ATTACK_STEP     = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_RELEASE_STEP    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_VOICE_LEVEL     = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_LOOP_ENABLE     = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_SAMPLE_LENGTH   = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_SOURCE_CHANNELS = 3'd6;

  localparam logic [19:0] RST_RATE_STEP       = 20'd65536;
  localparam logic [15:0] RST_ATTACK_STEP     = 16'd33;
  localparam logic [15:0] RST_RELEASE_STEP    = 16'd33;
  localparam logic [15:0] RST_VOICE_LEVEL     = 16'd16384;
  localparam logic        RST_LOOP_ENABLE     = 1'b1;
  localparam logic [16:0] RST_SAMPLE_LENGTH   = 17'd65536;
  localparam logic [1:0]  RST_SOURCE_CHANNELS = 2'd2;

  localparam logic [15:0] FULL_GAIN     = 16'd32768;
  localparam logic [15:0] OFF_THRESHOLD = 16'd3;
  localparam logic [16:0] MIN_LENGTH    = 17'd16;

  // remainder unit: 17-bit dividend and divisor
  localparam int ModBits = 17;
  localparam int ModCntW = $clog2(ModBits + 1);

  typedef enum logic [1:0] {
    KIND_WRITE   = 2'd0,
    KIND_TRIGGER = 2'd1,
    KIND_STOP    = 2'd2,
    KIND_TICK    = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_IMOD,
    ST_RD0,
    ST_RD1,
    ST_MDL,
    ST_MDR,
    ST_MGL,
    ST_MVL,
    ST_MGR,
    ST_MVR,
    ST_RNDR,
    ST_SATR,
    ST_PMOD,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic               start;
    logic [ModBits-1:0] dividend;
    logic [ModBits-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic               done;
    logic [ModBits-1:0] rem;
  } mod_rsp_t;

endpackage

/* hw/rtl/spv_mod_unit.sv */
// -----------------------------------------------------------------------------
// Sample playback voice: remainder unit
// Restoring remainder, one dividend bit per cycle; done pulses after the last bit.
// -----------------------------------------------------------------------------
module spv_mod_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  spv_pkg::mod_req_t req_i,
  output spv_pkg::mod_rsp_t rsp_o
);

  logic                        busy_q;
  logic [spv_pkg::ModCntW-1:0] cnt_q;
  logic [spv_pkg::ModBits-1:0] num_q;
  logic [spv_pkg::ModBits-1:0] div_q;
  logic [spv_pkg::ModBits-1:0] rem_q;
  logic [spv_pkg::ModBits-1:0] rem_d;
  logic [spv_pkg::ModBits:0]   trial;

  always_comb begin
    trial = {rem_q, num_q[spv_pkg::ModBits-1]};
    if (trial >= {1'b0, div_q}) begin
      rem_d = spv_pkg::ModBits'(trial - {1'b0, div_q});
    end else begin
      rem_d = trial[spv_pkg::ModBits-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= spv_pkg::ModCntW'(spv_pkg::ModBits);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= req_i.dividend;
      div_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q && (cnt_q != '0)) begin
      num_q <= {num_q[spv_pkg::ModBits-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign rsp_o.done = busy_q && (cnt_q == '0);
  assign rsp_o.rem  = rem_q;

endmodule

/* hw/rtl/sample_playback_voice_unit.sv */
// -----------------------------------------------------------------------------
// Sample playback voice unit
// One sampler voice: stores stereo frames, ramps gain, interpolates linearly at
// a 16.16 phase and mixes the scaled voice onto an incoming stereo sample.
//
//   channel   direction  contents
//   s_axis    in         tuser kind; tdata address, write samples, mix samples
//   m_axis    out        tdata mixed samples, voice on flag, current gain
//   cfg       in         register index and write data, always ready
//
// Write, trigger and stop items finish in the idle state; a tick holds off new
// items until it returns there. On a playing voice a tick makes two store reads
// and six passes through the one shared multiplier; it uses the remainder
// unit when the phase lies beyond the length in use and when a loop wrap still
// leaves the phase past the end. A result waits in the output register; a
// stalled output holds the next tick in the output state.
// After reset the voice is silent and the sample store is unwritten.
// -----------------------------------------------------------------------------
`include "sample_playback_voice_unit_macros.svh"

module sample_playback_voice_unit #(
  parameter int STORE_DEPTH = spv_pkg::DefStoreDepth,
  parameter int SAMPLE_BITS = spv_pkg::DefSampleBits
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // frame_address, write_left, write_right, mix_left, mix_right
  input  logic [79:0]                  s_axis_tdata,
  // kind
  input  logic [1:0]                   s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // out_left, out_right, voice_on, level_now, zero padding
  output logic [55:0]                  m_axis_tdata,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [spv_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [spv_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int SBK    = (SAMPLE_BITS < 16) ? SAMPLE_BITS : 16;
  localparam int DROP   = 16 - SBK;
  localparam int AW     = $clog2(STORE_DEPTH);
  localparam int MAXLEN = (STORE_DEPTH < 65536) ? STORE_DEPTH : 65536;

  function automatic logic signed [15:0] left_of(logic [2*SBK-1:0] e);
    return 16'(e[SBK-1:0]) << DROP;
  endfunction

  function automatic logic signed [15:0] right_of(logic [2*SBK-1:0] e);
    return 16'(e[2*SBK-1:SBK]) << DROP;
  endfunction

  function automatic logic signed [15:0] sat_add(logic signed [15:0] a,
                                                 logic signed [17:0] c);
    logic signed [18:0] s;
    s = 19'(a) + 19'(c);
    if (s > 19'sd32767) begin
      return 16'sh7fff;
    end else if (s < -19'sd32768) begin
      return 16'sh8000;
    end
    return s[15:0];
  endfunction

  // configuration
  logic [19:0] rate_step_q;
  logic [15:0] attack_q;
  logic [15:0] release_q;
  logic [15:0] level_q;
  logic        loop_q;
  logic [16:0] sample_len_q;
  logic [1:0]  channels_q;

  // voice state
  spv_pkg::state_e state_q, state_d;
  logic [31:0] phase_q;
  logic [15:0] ramp_q;
  logic [15:0] target_q;
  logic        playing_q;

  // datapath
  logic [2*SBK-1:0]   store_mem [STORE_DEPTH];
  logic [2*SBK-1:0]   rdata_q;
  logic [2*SBK-1:0]   w0_q;
  logic [15:0]        i0_q;
  logic [15:0]        i1_q;
  logic signed [15:0] mix_l_q, mix_r_q;
  logic signed [15:0] out_l_q, out_r_q;
  logic signed [15:0] vl_q, vr_q;
  logic signed [48:0] prod_q;
  logic signed [17:0] c_q;
  logic [32:0]        np_q;
  logic               m_valid_q;
  logic [55:0]        m_data_q;

  logic               in_fire;
  spv_pkg::kind_e     kind;
  logic [16:0]        len;
  logic               idx_wrap;
  logic [15:0]        ramp_next;
  logic [16:0]        att_sum;
  logic [16:0]        i0_inc;
  logic [15:0]        i1_next;
  logic [32:0]        end_w;
  logic [32:0]        np_sub;
  logic               past_end;
  logic               past_twice;
  logic               wrap_mod;
  logic               off_cond;
  logic               out_load;
  logic               rd_en;
  logic [15:0]        rd_idx;
  logic               mul_en;
  logic signed [31:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [48:0] mul_p;
  logic signed [48:0] rnd;
  logic signed [15:0] w0_l, w0_r, w1_l, w1_r;
  logic signed [16:0] diff_l, diff_r;
  logic signed [15:0] lerp_l, lerp_r;

  spv_pkg::mod_req_t mod_req;
  spv_pkg::mod_rsp_t mod_rsp;

  spv_mod_unit u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .rsp_o  (mod_rsp)
  );

  assign in_fire     = s_axis_tvalid && s_axis_tready;
  assign kind        = spv_pkg::kind_e'(s_axis_tuser);
  assign cfg_ready_o = 1'b1;

  always_comb begin
    if (sample_len_q < spv_pkg::MIN_LENGTH) begin
      len = spv_pkg::MIN_LENGTH;
    end else if (sample_len_q > 17'(MAXLEN)) begin
      len = 17'(MAXLEN);
    end else begin
      len = sample_len_q;
    end
  end

  assign idx_wrap = {1'b0, phase_q[31:16]} >= len;

  // gain ramp toward the target
  always_comb begin
    att_sum   = {1'b0, ramp_q} + {1'b0, attack_q};
    ramp_next = ramp_q;
    if (ramp_q < target_q) begin
      ramp_next = (att_sum < {1'b0, target_q}) ? att_sum[15:0] : target_q;
    end else if (ramp_q > target_q) begin
      ramp_next = ((ramp_q - target_q) > release_q) ? (ramp_q - release_q) : target_q;
    end
  end

  assign i0_inc  = {1'b0, i0_q} + 17'd1;
  assign i1_next = (i0_inc == len) ? 16'd0 : i0_inc[15:0];

  assign end_w      = {len, 16'd0};
  assign np_sub     = np_q - end_w;
  assign past_end   = np_q >= end_w;
  assign past_twice = {1'b0, np_q} >= {len, 17'd0};
  assign wrap_mod   = past_end && loop_q && past_twice;

  assign off_cond = playing_q && (ramp_q <= spv_pkg::OFF_THRESHOLD)
                    && (target_q <= spv_pkg::OFF_THRESHOLD);

  assign w0_l   = left_of(w0_q);
  assign w0_r   = right_of(w0_q);
  assign w1_l   = left_of(rdata_q);
  assign w1_r   = right_of(rdata_q);
  assign diff_l = 17'(w1_l) - 17'(w0_l);
  assign diff_r = 17'(w1_r) - 17'(w0_r);
  // result lies between the two samples, so 16-bit wrap is exact
  assign lerp_l = w0_l + prod_q[31:16];
  assign lerp_r = w0_r + prod_q[31:16];
  assign rnd    = prod_q + 49'sd536870912;
  assign mul_p  = 49'(mul_a) * 49'(mul_b);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      spv_pkg::ST_IDLE: begin
        if (in_fire && (kind == spv_pkg::KIND_TICK)) begin
          if (!playing_q) begin
            state_d = spv_pkg::ST_OUT;
          end else if (idx_wrap) begin
            state_d = spv_pkg::ST_IMOD;
          end else begin
            state_d = spv_pkg::ST_RD0;
          end
        end
      end
      spv_pkg::ST_IMOD: begin
        if (mod_rsp.done) begin
          state_d = spv_pkg::ST_RD0;
        end
      end
      spv_pkg::ST_RD0:  state_d = spv_pkg::ST_RD1;
      spv_pkg::ST_RD1:  state_d = spv_pkg::ST_MDL;
      spv_pkg::ST_MDL:  state_d = spv_pkg::ST_MDR;
      spv_pkg::ST_MDR:  state_d = spv_pkg::ST_MGL;
      spv_pkg::ST_MGL:  state_d = spv_pkg::ST_MVL;
      spv_pkg::ST_MVL:  state_d = spv_pkg::ST_MGR;
      spv_pkg::ST_MGR:  state_d = spv_pkg::ST_MVR;
      spv_pkg::ST_MVR:  state_d = spv_pkg::ST_RNDR;
      spv_pkg::ST_RNDR: state_d = spv_pkg::ST_SATR;
      spv_pkg::ST_SATR: state_d = wrap_mod ? spv_pkg::ST_PMOD : spv_pkg::ST_OUT;
      spv_pkg::ST_PMOD: begin
        if (mod_rsp.done) begin
          state_d = spv_pkg::ST_OUT;
        end
      end
      spv_pkg::ST_OUT: begin
        if (out_load) begin
          state_d = spv_pkg::ST_IDLE;
        end
      end
      default: state_d = spv_pkg::ST_IDLE;
    endcase
  end

  // control outputs and shared multiplier operands
  always_comb begin
    s_axis_tready    = 1'b0;
    out_load         = 1'b0;
    rd_en            = 1'b0;
    rd_idx           = i0_q;
    mul_en           = 1'b0;
    mul_a            = '0;
    mul_b            = '0;
    mod_req.start    = 1'b0;
    mod_req.dividend = {1'b0, phase_q[31:16]};
    mod_req.divisor  = len;
    case (state_q)
      spv_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        mod_req.start = in_fire && (kind == spv_pkg::KIND_TICK) && playing_q && idx_wrap;
      end
      spv_pkg::ST_RD0: rd_en = 1'b1;
      spv_pkg::ST_RD1: begin
        rd_en  = 1'b1;
        rd_idx = i1_q;
      end
      spv_pkg::ST_MDL: begin
        mul_en = 1'b1;
        mul_a  = 32'(diff_l);
        mul_b  = {1'b0, phase_q[15:0]};
      end
      spv_pkg::ST_MDR: begin
        mul_en = 1'b1;
        mul_a  = 32'(diff_r);
        mul_b  = {1'b0, phase_q[15:0]};
      end
      spv_pkg::ST_MGL: begin
        mul_en = 1'b1;
        mul_a  = 32'(vl_q);
        mul_b  = {1'b0, ramp_q};
      end
      spv_pkg::ST_MVL, spv_pkg::ST_MVR: begin
        mul_en = 1'b1;
        mul_a  = prod_q[31:0];
        mul_b  = {1'b0, level_q};
      end
      spv_pkg::ST_MGR: begin
        mul_en = 1'b1;
        mul_a  = 32'(vr_q);
        mul_b  = {1'b0, ramp_q};
      end
      spv_pkg::ST_SATR: begin
        mod_req.start    = wrap_mod;
        mod_req.dividend = np_sub[32:16];
      end
      spv_pkg::ST_OUT: out_load = !m_valid_q || m_axis_tready;
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= spv_pkg::ST_IDLE;
      phase_q      <= '0;
      ramp_q       <= '0;
      target_q     <= '0;
      playing_q    <= 1'b0;
      m_valid_q    <= 1'b0;
      rate_step_q  <= spv_pkg::RST_RATE_STEP;
      attack_q     <= spv_pkg::RST_ATTACK_STEP;
      release_q    <= spv_pkg::RST_RELEASE_STEP;
      level_q      <= spv_pkg::RST_VOICE_LEVEL;
      loop_q       <= spv_pkg::RST_LOOP_ENABLE;
      sample_len_q <= spv_pkg::RST_SAMPLE_LENGTH;
      channels_q   <= spv_pkg::RST_SOURCE_CHANNELS;
    end else begin
      state_q <= state_d;

      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          spv_pkg::CFG_RATE_STEP:       rate_step_q  <= cfg_data_i;
          spv_pkg::CFG_ATTACK_STEP:     attack_q     <= cfg_data_i[15:0];
          spv_pkg::CFG_RELEASE_STEP:    release_q    <= cfg_data_i[15:0];
          spv_pkg::CFG_VOICE_LEVEL:     level_q      <= cfg_data_i[15:0];
          spv_pkg::CFG_LOOP_ENABLE:     loop_q       <= cfg_data_i[0];
          spv_pkg::CFG_SAMPLE_LENGTH:   sample_len_q <= cfg_data_i[16:0];
          spv_pkg::CFG_SOURCE_CHANNELS: channels_q   <= cfg_data_i[1:0];
          default: ;
        endcase
      end

      if ((state_q == spv_pkg::ST_IDLE) && in_fire) begin
        case (kind)
          spv_pkg::KIND_TRIGGER: begin
            phase_q   <= '0;
            ramp_q    <= '0;
            target_q  <= spv_pkg::FULL_GAIN;
            playing_q <= 1'b1;
          end
          spv_pkg::KIND_STOP: target_q <= '0;
          spv_pkg::KIND_TICK: begin
            if (playing_q) begin
              ramp_q <= ramp_next;
            end
          end
          default: ;
        endcase
      end

      // advance the phase: wrap or end the voice
      if (state_q == spv_pkg::ST_SATR) begin
        if (!past_end) begin
          phase_q <= np_q[31:0];
        end else if (loop_q) begin
          if (!past_twice) begin
            phase_q <= np_sub[31:0];
          end
        end else begin
          playing_q <= 1'b0;
          ramp_q    <= '0;
          target_q  <= '0;
        end
      end

      if ((state_q == spv_pkg::ST_PMOD) && mod_rsp.done) begin
        phase_q <= {mod_rsp.rem[15:0], np_q[15:0]};
      end

      if (out_load) begin
        m_valid_q <= 1'b1;
        if (off_cond) begin
          playing_q <= 1'b0;
        end
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // sample store
  always_ff @(posedge clk_i) begin
    if ((state_q == spv_pkg::ST_IDLE) && in_fire && (kind == spv_pkg::KIND_WRITE)
        && (32'(s_axis_tdata[15:0]) < 32'(STORE_DEPTH))) begin
      store_mem[AW'(s_axis_tdata[15:0])] <= {s_axis_tdata[47 -: SBK],
                                             s_axis_tdata[31 -: SBK]};
    end
    if (rd_en) begin
      rdata_q <= store_mem[AW'(rd_idx)];
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if ((state_q == spv_pkg::ST_IDLE) && in_fire && (kind == spv_pkg::KIND_TICK)) begin
      mix_l_q <= $signed(s_axis_tdata[63:48]);
      mix_r_q <= $signed(s_axis_tdata[79:64]);
      out_l_q <= $signed(s_axis_tdata[63:48]);
      out_r_q <= $signed(s_axis_tdata[79:64]);
      i0_q    <= phase_q[31:16];
    end
    if ((state_q == spv_pkg::ST_IMOD) && mod_rsp.done) begin
      i0_q <= mod_rsp.rem[15:0];
    end
    if (state_q == spv_pkg::ST_RD0) begin
      i1_q <= i1_next;
    end
    if (state_q == spv_pkg::ST_RD1) begin
      w0_q <= rdata_q;
    end
    if (mul_en) begin
      prod_q <= mul_p;
    end
    if (state_q == spv_pkg::ST_MDR) begin
      vl_q <= lerp_l;
    end
    if (state_q == spv_pkg::ST_MGL) begin
      // mono sources repeat the left channel
      vr_q <= channels_q[1] ? lerp_r : vl_q;
    end
    if (state_q == spv_pkg::ST_MGR) begin
      c_q <= rnd[47:30];
    end
    if (state_q == spv_pkg::ST_MVR) begin
      out_l_q <= sat_add(mix_l_q, c_q);
    end
    if (state_q == spv_pkg::ST_RNDR) begin
      c_q  <= rnd[47:30];
      np_q <= {1'b0, phase_q} + 33'(rate_step_q);
    end
    if (state_q == spv_pkg::ST_SATR) begin
      out_r_q <= sat_add(mix_r_q, c_q);
    end
    if (out_load) begin
      m_data_q <= {7'd0, ramp_q, playing_q && !off_cond, out_r_q, out_l_q};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  `SPV_ASSERT_IMPLIES(a_mod_done_awaited, mod_rsp.done, (state_q == spv_pkg::ST_IMOD) || (state_q == spv_pkg::ST_PMOD), "remainder finished while no state awaits it")
  `SPV_ASSERT_IMPLIES(a_read_in_length, state_q == spv_pkg::ST_RD1, ({1'b0, i0_q} < len) && ({1'b0, i1_q} < len), "store read index beyond length in use")
  `SPV_ASSERT_IMPLIES(a_result_from_out, $rose(m_axis_tvalid), $past(state_q == spv_pkg::ST_OUT), "result raised outside the output state")

endmodule
